/* src/fbsp_pkg.sv */
`default_nettype none
package fbsp_pkg;

  // Side width after validation: max_dimension is 15 bits, so a legal side fits here.
  localparam int SIDE_W   = 15;
  localparam int PIX_W    = 2 * SIDE_W;
  localparam int MAXDIM_W = 15;
  localparam int BUDGET_W = 35;
  localparam int CFG_W    = 35;
  localparam int CFG_IDX_W = 1;

  localparam int ERR_W       = 3;
  localparam int COLOR_W     = 32;
  localparam int MSAMP_W     = 34;
  localparam int MIP_W       = 31;
  localparam int TOTAL_W     = 35;

  localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NONPOSITIVE = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_SAMPLES = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OVER_BUDGET = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIMENSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET   = 1'd1;

  localparam logic [7:0] MSAA_SAMPLES = 8'd4;

  localparam logic [MAXDIM_W-1:0] MAX_DIMENSION_RST = 15'd16384;
  localparam logic [BUDGET_W-1:0] BYTE_BUDGET_RST   = 35'd1073741824;

  // Operands handed to the shared multiplier.
  typedef struct packed {
    logic [SIDE_W-1:0] a;
    logic [SIDE_W-1:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

/* src/framebuffer_size_planner.sv */
`default_nettype none
// Framebuffer size planner. One transaction on the in_ channel describes a
// framebuffer (signed width and height, sample count, depth/stencil/mip flags);
// exactly one transaction on the out_ channel returns an error code and the
// byte size of every plane plus the total. Validation order: nonpositive side
// (1), side above max_dimension (2), sample count other than 0 or 4 (3); these
// report all sizes as zero. A total above byte_budget reports code 5 with the
// sizes intact. Code 4 is reserved and never produced. A single registered
// 15x15 multiplier is shared by the base level and every mip level, one level
// per cycle under a small sequencer. A rejected request goes from acceptance
// straight to the emit state; an accepted one steps through the base product,
// the L reduced mip levels (L is 0 without want_mips, at most 14), the tail,
// two sums and emit. The next request is accepted in the cycle after the
// result is loaded; loading waits while a stalled result holds the output
// register. The block is stalled while a request is in flight; a finished
// result waits in the output register while the next request is already
// accepted. Write cfg_ registers only while the block is idle.
module framebuffer_size_planner #(
  parameter int DIM_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration
  input  wire                                 cfg_we,
  input  wire  [fbsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [fbsp_pkg::CFG_W-1:0]          cfg_data,
  // request channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [DIM_BITS-1:0]          in_width,
  input  wire  signed [DIM_BITS-1:0]          in_height,
  input  wire  [7:0]                          in_sample_count,
  input  wire                                 in_want_depth,
  input  wire                                 in_want_stencil,
  input  wire                                 in_want_mips,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [fbsp_pkg::ERR_W-1:0]          out_error_code,
  output logic [fbsp_pkg::PIX_W-1:0]          out_pixel_count,
  output logic [fbsp_pkg::COLOR_W-1:0]        out_color_bytes,
  output logic [fbsp_pkg::PIX_W-1:0]          out_depth_elements,
  output logic [fbsp_pkg::COLOR_W-1:0]        out_depth_bytes,
  output logic [fbsp_pkg::PIX_W-1:0]          out_stencil_bytes,
  output logic [fbsp_pkg::MSAMP_W-1:0]        out_multisample_bytes,
  output logic [fbsp_pkg::MIP_W-1:0]          out_mip_bytes,
  output logic [fbsp_pkg::TOTAL_W-1:0]        out_total_bytes
);
  import fbsp_pkg::*;

  // Compare width: wide enough for both a side and max_dimension.
  localparam int CMP_W = (DIM_BITS - 1 > MAXDIM_W) ? (DIM_BITS - 1) : MAXDIM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULT = 3'd1;  // base product in flight
  localparam logic [2:0] S_MIP  = 3'd2;  // one reduced level per cycle
  localparam logic [2:0] S_TAIL = 3'd3;  // drain the last product
  localparam logic [2:0] S_SUMA = 3'd4;  // color + depth + stencil
  localparam logic [2:0] S_SUMB = 3'd5;  // + multisample + mip
  localparam logic [2:0] S_EMIT = 3'd6;  // budget check, load output

  logic [2:0]            state_r, state_nxt;
  logic [MAXDIM_W-1:0]   max_dim_r;
  logic [BUDGET_W-1:0]   budget_r;

  logic [SIDE_W-1:0]     sw_r, sw_nxt, sh_r, sh_nxt;
  logic                  depth_r, depth_nxt, stencil_r, stencil_nxt;
  logic                  msaa_r, msaa_nxt, mips_r, mips_nxt;
  logic                  first_r, first_nxt;
  logic [ERR_W-1:0]      err_r, err_nxt;
  logic [PIX_W-1:0]      pix_r, pix_nxt;
  logic [MIP_W-1:0]      acc_r, acc_nxt;
  logic [TOTAL_W-1:0]    tot_r, tot_nxt;

  logic [PIX_W-1:0]      prod_r;
  mul_req_t              mul_req;

  logic                  in_accept, out_free;
  logic                  w_pos, h_pos, w_big, h_big, samp_ok;
  logic [CMP_W-1:0]      w_ext, h_ext;
  logic                  sides_one;
  logic [SIDE_W-1:0]     sw_half, sh_half;
  logic [COLOR_W-1:0]    color_b, depth_b;
  logic [PIX_W-1:0]      stencil_b;
  logic [MSAMP_W-1:0]    msaa_b;
  logic [MIP_W-1:0]      level_b;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r <= MAX_DIMENSION_RST;
      budget_r  <= BYTE_BUDGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DIMENSION: max_dim_r <= cfg_data[MAXDIM_W-1:0];
        REG_BYTE_BUDGET:   budget_r  <= cfg_data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- request checks ----------------
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign w_pos   = !in_width[DIM_BITS-1] && (|in_width[DIM_BITS-2:0]);
  assign h_pos   = !in_height[DIM_BITS-1] && (|in_height[DIM_BITS-2:0]);
  assign w_ext   = CMP_W'(in_width[DIM_BITS-2:0]);
  assign h_ext   = CMP_W'(in_height[DIM_BITS-2:0]);
  assign w_big   = w_ext > CMP_W'(max_dim_r);
  assign h_big   = h_ext > CMP_W'(max_dim_r);
  assign samp_ok = (in_sample_count == 8'd0) || (in_sample_count == MSAA_SAMPLES);

  // ---------------- shared multiplier ----------------
  assign mul_req.a = sw_r;
  assign mul_req.b = sh_r;

  fbsp_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  // Halve with floor, hold at 1.
  assign sides_one = (sw_r == SIDE_W'(1)) && (sh_r == SIDE_W'(1));
  assign sw_half   = (sw_r > SIDE_W'(1)) ? (sw_r >> 1) : SIDE_W'(1);
  assign sh_half   = (sh_r > SIDE_W'(1)) ? (sh_r >> 1) : SIDE_W'(1);
  assign level_b   = MIP_W'({prod_r, 2'b00});

  // Plane sizes derived from the pixel count (zero after a rejection).
  assign color_b   = {pix_r, 2'b00};
  assign depth_b   = depth_r ? color_b : '0;
  assign stencil_b = stencil_r ? pix_r : '0;
  assign msaa_b    = msaa_r ? {pix_r, 4'b0000} : '0;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    sw_nxt      = sw_r;
    sh_nxt      = sh_r;
    depth_nxt   = depth_r;
    stencil_nxt = stencil_r;
    msaa_nxt    = msaa_r;
    mips_nxt    = mips_r;
    first_nxt   = first_r;
    err_nxt     = err_r;
    pix_nxt     = pix_r;
    acc_nxt     = acc_r;
    tot_nxt     = tot_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          sw_nxt      = w_ext[SIDE_W-1:0];
          sh_nxt      = h_ext[SIDE_W-1:0];
          pix_nxt     = '0;
          acc_nxt     = '0;
          tot_nxt     = '0;
          first_nxt   = 1'b1;
          depth_nxt   = 1'b0;
          stencil_nxt = 1'b0;
          msaa_nxt    = 1'b0;
          mips_nxt    = 1'b0;
          if (!w_pos || !h_pos) begin
            err_nxt   = ERR_NONPOSITIVE;
            state_nxt = S_EMIT;
          end else if (w_big || h_big) begin
            err_nxt   = ERR_TOO_LARGE;
            state_nxt = S_EMIT;
          end else if (!samp_ok) begin
            err_nxt   = ERR_BAD_SAMPLES;
            state_nxt = S_EMIT;
          end else begin
            err_nxt     = ERR_OK;
            depth_nxt   = in_want_depth;
            stencil_nxt = in_want_stencil;
            msaa_nxt    = (in_sample_count == MSAA_SAMPLES);
            mips_nxt    = in_want_mips;
            state_nxt   = S_MULT;
          end
        end
      end
      S_MULT: begin
        // base product is being registered this cycle
        if (mips_r && !sides_one) begin
          sw_nxt    = sw_half;
          sh_nxt    = sh_half;
          state_nxt = S_MIP;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_MIP: begin
        // prod_r holds the previous level (or the base on the first pass)
        if (first_r) begin
          pix_nxt = prod_r;
        end else begin
          acc_nxt = acc_r + level_b;
        end
        first_nxt = 1'b0;
        if (sides_one) begin
          state_nxt = S_TAIL;
        end else begin
          sw_nxt = sw_half;
          sh_nxt = sh_half;
        end
      end
      S_TAIL: begin
        if (first_r) begin
          pix_nxt = prod_r;
        end else begin
          acc_nxt = acc_r + level_b;
        end
        first_nxt = 1'b0;
        state_nxt = S_SUMA;
      end
      S_SUMA: begin
        tot_nxt   = TOTAL_W'(color_b) + TOTAL_W'(depth_b) + TOTAL_W'(stencil_b);
        state_nxt = S_SUMB;
      end
      S_SUMB: begin
        tot_nxt   = tot_r + TOTAL_W'(msaa_b) + TOTAL_W'(acc_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_r      <= sw_nxt;
    sh_r      <= sh_nxt;
    depth_r   <= depth_nxt;
    stencil_r <= stencil_nxt;
    msaa_r    <= msaa_nxt;
    mips_r    <= mips_nxt;
    err_r     <= err_nxt;
    pix_r     <= pix_nxt;
    acc_r     <= acc_nxt;
    tot_r     <= tot_nxt;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      if (err_r != ERR_OK) begin
        out_error_code <= err_r;
      end else if (tot_r > budget_r) begin
        out_error_code <= ERR_OVER_BUDGET;
      end else begin
        out_error_code <= ERR_OK;
      end
      out_pixel_count       <= pix_r;
      out_color_bytes       <= color_b;
      out_depth_elements    <= depth_r ? pix_r : '0;
      out_depth_bytes       <= depth_b;
      out_stencil_bytes     <= stencil_b;
      out_multisample_bytes <= msaa_b;
      out_mip_bytes         <= acc_r;
      out_total_bytes       <= tot_r;
    end
  end

endmodule
`default_nettype wire

/* src/fbsp_mul.sv */
`default_nettype none
module fbsp_mul (
  input  wire                      clk,
  input  wire fbsp_pkg::mul_req_t  req,
  output logic [fbsp_pkg::PIX_W-1:0] prod_r
);
  import fbsp_pkg::*;

  // Registered 15x15 product; the result appears in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= PIX_W'(req.a) * PIX_W'(req.b);
  end

endmodule
`default_nettype wire

/* src/fbsp_checker.sv */
`default_nettype none
module fbsp_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire [fbsp_pkg::ERR_W-1:0]          out_error_code,
  input wire [fbsp_pkg::PIX_W-1:0]          out_pixel_count,
  input wire [fbsp_pkg::COLOR_W-1:0]        out_color_bytes,
  input wire [fbsp_pkg::COLOR_W-1:0]        out_depth_bytes,
  input wire [fbsp_pkg::PIX_W-1:0]          out_stencil_bytes,
  input wire [fbsp_pkg::MSAMP_W-1:0]        out_multisample_bytes,
  input wire [fbsp_pkg::MIP_W-1:0]          out_mip_bytes,
  input wire [fbsp_pkg::TOTAL_W-1:0]        out_total_bytes
);
  import fbsp_pkg::*;

  // Rejected requests carry no sizes.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_NONPOSITIVE || out_error_code == ERR_TOO_LARGE ||
                  out_error_code == ERR_BAD_SAMPLES)
    |-> out_pixel_count == '0 && out_total_bytes == '0 && out_mip_bytes == '0)
    else $error("rejected request reports nonzero size");

  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_color_bytes == {out_pixel_count, 2'b00})
    else $error("color bytes not four per pixel");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_bytes == TOTAL_W'(out_color_bytes) + TOTAL_W'(out_depth_bytes)
      + TOTAL_W'(out_stencil_bytes) + TOTAL_W'(out_multisample_bytes)
      + TOTAL_W'(out_mip_bytes))
    else $error("total does not match plane sum");

  // A request occupies the block for at least the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after a transaction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_bytes))
    else $error("stalled result changed");

endmodule

bind framebuffer_size_planner fbsp_checker u_fbsp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_error_code        (out_error_code),
  .out_pixel_count       (out_pixel_count),
  .out_color_bytes       (out_color_bytes),
  .out_depth_bytes       (out_depth_bytes),
  .out_stencil_bytes     (out_stencil_bytes),
  .out_multisample_bytes (out_multisample_bytes),
  .out_mip_bytes         (out_mip_bytes),
  .out_total_bytes       (out_total_bytes)
);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for framebuffer_size_planner.
// Every accepted request transaction is run through a local plan model;
// the resulting plan is queued and compared field by field against the next
// accepted result transaction.
module tb_top;
  import fbsp_pkg::*;

  localparam int DIM_BITS     = 16;
  localparam int LIMIT_CYCLES = 1_000_000;
  // Long receiver hold-off: far longer than one request takes, so the
  // output register and the sequencer both fill and in_stall rises.
  localparam int HOLD_CYCLES  = 400;
  // Settle margin, longer than the worst request (14 reduced mip levels).
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic signed [DIM_BITS-1:0] width;
    logic signed [DIM_BITS-1:0] height;
    logic [7:0]                 sample_count;
    logic                       want_depth;
    logic                       want_stencil;
    logic                       want_mips;
  } req_t;

  typedef struct packed {
    logic [ERR_W-1:0]   error_code;
    logic [PIX_W-1:0]   pixel_count;
    logic [COLOR_W-1:0] color_bytes;
    logic [PIX_W-1:0]   depth_elements;
    logic [COLOR_W-1:0] depth_bytes;
    logic [PIX_W-1:0]   stencil_bytes;
    logic [MSAMP_W-1:0] multisample_bytes;
    logic [MIP_W-1:0]   mip_bytes;
    logic [TOTAL_W-1:0] total_bytes;
  } plan_t;

  // ---------------------------------------------------------------------
  // Clock, reset and DUT signals (bench-driven ones set to known values at time 0)
  // ---------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_MAX_DIMENSION;
  logic [CFG_W-1:0]           cfg_data  = '0;

  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic signed [DIM_BITS-1:0] in_width        = '0;
  logic signed [DIM_BITS-1:0] in_height       = '0;
  logic [7:0]                 in_sample_count = '0;
  logic                       in_want_depth   = 1'b0;
  logic                       in_want_stencil = 1'b0;
  logic                       in_want_mips    = 1'b0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ERR_W-1:0]           out_error_code;
  logic [PIX_W-1:0]           out_pixel_count;
  logic [COLOR_W-1:0]         out_color_bytes;
  logic [PIX_W-1:0]           out_depth_elements;
  logic [COLOR_W-1:0]         out_depth_bytes;
  logic [PIX_W-1:0]           out_stencil_bytes;
  logic [MSAMP_W-1:0]         out_multisample_bytes;
  logic [MIP_W-1:0]           out_mip_bytes;
  logic [TOTAL_W-1:0]         out_total_bytes;

  always #2 clk = ~clk;

  framebuffer_size_planner #(.DIM_BITS(DIM_BITS)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_width              (in_width),
    .in_height             (in_height),
    .in_sample_count       (in_sample_count),
    .in_want_depth         (in_want_depth),
    .in_want_stencil       (in_want_stencil),
    .in_want_mips          (in_want_mips),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_error_code        (out_error_code),
    .out_pixel_count       (out_pixel_count),
    .out_color_bytes       (out_color_bytes),
    .out_depth_elements    (out_depth_elements),
    .out_depth_bytes       (out_depth_bytes),
    .out_stencil_bytes     (out_stencil_bytes),
    .out_multisample_bytes (out_multisample_bytes),
    .out_mip_bytes         (out_mip_bytes),
    .out_total_bytes       (out_total_bytes)
  );

  // ---------------------------------------------------------------------
  // Local copy of the registers, plan queue, bookkeeping
  // ---------------------------------------------------------------------
  logic [MAXDIM_W-1:0] plan_max_dim = MAX_DIMENSION_RST;
  logic [BUDGET_W-1:0] plan_budget  = BYTE_BUDGET_RST;

  plan_t plan_q[$];
  plan_t want;

  int send_idle_pct  = 0;   // chance per cycle that the sender sits idle
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_req       = 0;   // bumped by a test to ask for a long hold-off
  int hold_done      = 0;   // hold-offs the receiver has started
  int hold_left      = 0;

  int error_count     = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int config_writes   = 0;
  int cycle_count     = 0;
  int code_seen [8];

  // ---------------------------------------------------------------------
  // Plan model: validation in priority order, then plane sizes, mip chain,
  // total and budget check. Arithmetic is done in 64 bits, then narrowed.
  // ---------------------------------------------------------------------
  function automatic plan_t plan_framebuffer(req_t r);
    plan_t p;
    longint unsigned w, h, pix, mw, mh, mips, total;
    p = '0;
    if ($signed(r.width) <= 0 || $signed(r.height) <= 0) begin
      p.error_code = ERR_NONPOSITIVE;
    end else if (longint'(r.width) > longint'(plan_max_dim) ||
                 longint'(r.height) > longint'(plan_max_dim)) begin
      p.error_code = ERR_TOO_LARGE;
    end else if (r.sample_count != 8'd0 && r.sample_count != MSAA_SAMPLES) begin
      p.error_code = ERR_BAD_SAMPLES;
    end else begin
      w   = longint'(r.width);
      h   = longint'(r.height);
      pix = w * h;
      p.pixel_count = pix[PIX_W-1:0];
      p.color_bytes = COLOR_W'(pix * 4);
      if (r.want_depth) begin
        p.depth_elements = pix[PIX_W-1:0];
        p.depth_bytes    = COLOR_W'(pix * 4);
      end
      if (r.want_stencil)
        p.stencil_bytes = pix[PIX_W-1:0];
      if (r.sample_count == MSAA_SAMPLES)
        p.multisample_bytes = MSAMP_W'(pix * 16);
      // Reduced levels only: floor halving, each side parks at 1.
      mips = 0;
      if (r.want_mips) begin
        mw = w;
        mh = h;
        while (mw > 1 || mh > 1) begin
          mw = (mw > 1) ? (mw >> 1) : 1;
          mh = (mh > 1) ? (mh >> 1) : 1;
          mips += mw * mh * 4;
        end
      end
      p.mip_bytes = mips[MIP_W-1:0];
      total = longint'(p.color_bytes) + longint'(p.depth_bytes) +
              longint'(p.stencil_bytes) + longint'(p.multisample_bytes) + mips;
      p.total_bytes = total[TOTAL_W-1:0];
      // Over budget still reports every size.
      p.error_code = (total > longint'(plan_budget)) ? ERR_OVER_BUDGET : ERR_OK;
    end
    return p;
  endfunction

  function automatic req_t make_request(int w, int h, int samples,
                                        int depth, int stencil, int mips);
    req_t r;
    r.width        = w[DIM_BITS-1:0];
    r.height       = h[DIM_BITS-1:0];
    r.sample_count = samples[7:0];
    r.want_depth   = depth[0];
    r.want_stencil = stencil[0];
    r.want_mips    = mips[0];
    return r;
  endfunction

  // Legal side in 1..top: tiny, anywhere, exactly top, or a power of two.
  function automatic logic signed [DIM_BITS-1:0] random_side(int unsigned top);
    int unsigned v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(1, (top < 16) ? top : 16);
      1:       v = $urandom_range(1, top);
      2:       v = top;
      default: v = 1 << $urandom_range(0, $clog2(top + 1) - 1);
    endcase
    return v[DIM_BITS-1:0];
  endfunction

  // Mostly well-formed requests with random content; the rest is noise
  // (wild sides, out-of-range sides, bad sample counts).
  function automatic req_t random_request();
    req_t r;
    int unsigned top;
    top = (plan_max_dim == 0) ? 1 : 32'(plan_max_dim);
    r.want_depth   = 1'($urandom_range(0, 1));
    r.want_stencil = 1'($urandom_range(0, 1));
    r.want_mips    = 1'($urandom_range(0, 1));
    r.width        = random_side(top);
    r.height       = random_side(top);
    r.sample_count = ($urandom_range(0, 1) != 0) ? MSAA_SAMPLES : 8'd0;
    if ($urandom_range(0, 99) >= 80) begin
      case ($urandom_range(0, 2))
        0: begin
          r.width        = DIM_BITS'($urandom);
          r.height       = DIM_BITS'($urandom);
          r.sample_count = 8'($urandom);
        end
        1: r.sample_count = 8'($urandom);
        default: begin
          if (top < 32767)
            r.height = DIM_BITS'($urandom_range(top + 1, 32767));
          else
            r.height = -DIM_BITS'($urandom_range(0, 32768));
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: optional idle cycles, then offer the request until accepted.
  // in_valid stays high after acceptance so back-to-back transactions never
  // lower and raise it in the same time step.
  // ---------------------------------------------------------------------
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_width        <= r.width;
    in_height       <= r.height;
    in_sample_count <= r.sample_count;
    in_want_depth   <= r.want_depth;
    in_want_stencil <= r.want_stencil;
    in_want_mips    <= r.want_mips;
    do @(posedge clk); while (in_stall !== 1'b0);
    plan_q.push_back(plan_framebuffer(r));
    requests_sent++;
  endtask

  // Registers change only with the block idle: every result back.
  task automatic set_config(input logic [CFG_W-1:0] max_dim_word,
                            input logic [CFG_W-1:0] budget_word);
    in_valid <= 1'b0;
    do @(posedge clk); while (plan_q.size() != 0);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_DIMENSION;
    cfg_data  <= max_dim_word;
    @(posedge clk);
    plan_max_dim = max_dim_word[MAXDIM_W-1:0];   // upper bits dropped
    cfg_index <= REG_BYTE_BUDGET;
    cfg_data  <= budget_word;
    @(posedge clk);
    plan_budget = budget_word[BUDGET_W-1:0];
    cfg_we <= 1'b0;
    config_writes += 2;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, or a long counted hold-off when requested.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] exp_v,
                                      logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("tb_top: %s mismatch, expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (plan_q.size() == 0) begin
        $error("tb_top: result transaction with no request outstanding");
        error_count++;
      end else begin
        want = plan_q.pop_front();
        check_field("error_code",     64'(want.error_code),     64'(out_error_code));
        check_field("pixel_count",    64'(want.pixel_count),    64'(out_pixel_count));
        check_field("color_bytes",    64'(want.color_bytes),    64'(out_color_bytes));
        check_field("depth_elements", 64'(want.depth_elements), 64'(out_depth_elements));
        check_field("depth_bytes",    64'(want.depth_bytes),    64'(out_depth_bytes));
        check_field("stencil_bytes",  64'(want.stencil_bytes),  64'(out_stencil_bytes));
        check_field("multisample_bytes", 64'(want.multisample_bytes),
                    64'(out_multisample_bytes));
        check_field("mip_bytes",      64'(want.mip_bytes),      64'(out_mip_bytes));
        check_field("total_bytes",    64'(want.total_bytes),    64'(out_total_bytes));
        code_seen[want.error_code]++;
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset register values: field extremes, check priority, every plane.
  task automatic test_directed_requests();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(make_request(1, 1, 0, 0, 0, 0));
    send_request(make_request(1, 1, 4, 1, 1, 1));          // 1x1: empty mip chain
    send_request(make_request(0, 5, 0, 0, 0, 0));          // zero side
    send_request(make_request(5, 0, 0, 1, 0, 0));
    send_request(make_request(-32768, 32767, 0, 0, 0, 0)); // nonpositive beats too large
    send_request(make_request(-1, -1, 7, 1, 1, 1));        // nonpositive beats samples
    send_request(make_request(16384, 16384, 0, 0, 0, 0));  // total equals budget: ok
    send_request(make_request(16384, 16384, 0, 1, 0, 0));  // over budget with depth
    send_request(make_request(16385, 1, 0, 0, 0, 0));      // side one above limit
    send_request(make_request(1, 32767, 3, 0, 0, 0));      // too large beats samples
    send_request(make_request(4, 4, 1, 0, 0, 0));
    send_request(make_request(4, 4, 255, 1, 1, 1));
    send_request(make_request(4, 4, 8, 0, 0, 0));
    send_request(make_request(8, 2, 0, 0, 0, 1));          // one side parks at 1
    send_request(make_request(1, 300, 0, 0, 1, 1));
    send_request(make_request(640, 480, 4, 1, 1, 1));
    send_request(make_request(16384, 1, 4, 1, 1, 1));      // longest mip chain
    send_request(make_request(3, 5, 0, 0, 0, 1));          // odd sides, floor halving
    send_request(make_request(16384, 16383, 4, 1, 1, 1));
  endtask

  // Register extremes, wide writes with upper bits set, zero max_dimension.
  task automatic test_register_extremes();
    set_config('1, '1);                                    // 32767, full budget
    send_request(make_request(32767, 32767, 4, 1, 1, 1));  // largest sizes
    send_request(make_request(32767, 32766, 0, 0, 0, 1));
    send_request(make_request(-32768, 1, 4, 0, 0, 0));
    set_config(35'h4_0000_8001, '0);                       // max_dimension 1, budget 0
    send_request(make_request(1, 1, 0, 0, 0, 0));          // 4 bytes over a zero budget
    send_request(make_request(2, 1, 0, 0, 0, 0));
    send_request(make_request(1, 1, 4, 1, 1, 1));
    set_config(35'h0_0000_8000, CFG_W'(BYTE_BUDGET_RST));  // max_dimension 0
    send_request(make_request(1, 1, 0, 0, 0, 0));
    send_request(make_request(0, 1, 0, 0, 0, 0));
    set_config(CFG_W'(MAX_DIMENSION_RST), CFG_W'(BYTE_BUDGET_RST));
  endtask

  // Random traffic under one idling pattern; registers reshuffled every
  // hundred requests.
  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    logic [CFG_W-1:0] dim_word, budget_word;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       dim_word = CFG_W'(32767);
          1:       dim_word = CFG_W'(MAX_DIMENSION_RST);
          2:       dim_word = CFG_W'($urandom_range(1, 32767));
          default: dim_word = CFG_W'($urandom_range(1, 64));
        endcase
        dim_word[CFG_W-1:MAXDIM_W] = (CFG_W-MAXDIM_W)'($urandom);  // ignored by the block
        case ($urandom_range(0, 7))
          0:       budget_word = '0;
          1:       budget_word = '1;
          2, 3:    budget_word = CFG_W'($urandom_range(0, 1 << 24));
          default: budget_word = {3'($urandom_range(0, 7)), $urandom};
        endcase
        set_config(dim_word, budget_word);
      end
      send_request(random_request());
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // transactions back to back; the block has to push back on in_stall.
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(CFG_W'(32767), '1);
    hold_req++;
    for (int i = 0; i < 30; i++)
      send_request(random_request());
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_requests();
    test_register_extremes();
    test_random_traffic(0, 0, 400);      // full rate
    test_random_traffic(75, 0, 380);     // sparse sender
    test_random_traffic(0, 75, 380);     // slow receiver
    test_random_traffic(34, 34, 380);    // both
    test_output_holdoff();

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests sent, %0d results checked, %0d register writes",
             requests_sent, results_checked, config_writes);
    $display("tb_top: codes ok %0d, nonpositive %0d, too large %0d,",
             code_seen[ERR_OK], code_seen[ERR_NONPOSITIVE], code_seen[ERR_TOO_LARGE]);
    $display("tb_top: bad samples %0d, over budget %0d",
             code_seen[ERR_BAD_SAMPLES], code_seen[ERR_OVER_BUDGET]);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
